// ===== hdl/ttg_pkg.sv =====
package ttg_pkg;

	localparam int TAN_W = 16;
	localparam int MAG_W = 15;
	localparam int THR_W = 16;
	localparam int OUT_W = 3 * TAN_W;
	localparam logic signed [TAN_W-1:0] ONE_Q14 = 16'sd16384;
	localparam logic [MAG_W-1:0] MAG_ONE = 15'd16384;

	localparam logic [1:0] PH_V0 = 2'd0;
	localparam logic [1:0] PH_V1 = 2'd1;
	localparam logic [1:0] PH_V2 = 2'd2;

	typedef enum logic {
		REG_DET_THR = 1'b0,
		REG_LEN_THR = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_BUSY,
		ST_OUT
	} top_state_t;

	typedef enum logic [4:0] {
		C_IDLE,
		C_F1, C_F1W, C_F2, C_F2W, C_FCHK,
		C_T1, C_T1W, C_T2, C_T2W, C_SQ, C_SQW, C_SCHK,
		C_L2, C_L2W, C_FF, C_FFW, C_LR, C_LRW,
		C_RT, C_RTW, C_BS, C_K, C_KW, C_KS, C_KSW,
		C_DONE
	} core_state_t;

	typedef struct packed {
		logic done;
		logic used_def;
	} core_stat_t;

endpackage

// ===== hdl/ttg_mul.sv =====
module ttg_mul #(
	parameter int W = 164
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] prod
);

	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] acc_q;
	logic         run_q;

	assign done = run_q && (b_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

// ===== hdl/ttg_core.sv =====
module ttg_core #(
	parameter int CW = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [CW:0]           e1 [3],
	input  logic signed [CW:0]           e2 [3],
	input  logic signed [CW:0]           du1,
	input  logic signed [CW:0]           dv1,
	input  logic signed [CW:0]           du2,
	input  logic signed [CW:0]           dv2,
	input  logic [ttg_pkg::THR_W-1:0]    det_thr,
	input  logic [ttg_pkg::THR_W-1:0]    len_thr,
	output ttg_pkg::core_stat_t          stat,
	output logic signed [ttg_pkg::TAN_W-1:0] tan [3]
);
	import ttg_pkg::*;

	localparam int DW = CW + 1;
	localparam int FW = 2 * CW + 2;
	localparam int BW = 4 * CW + 36;

	core_state_t state_q, state_d;

	logic              mul_start;
	logic [BW-1:0]     mul_a;
	logic [BW-1:0]     mul_b;
	logic              mul_done;
	logic [BW-1:0]     mul_p;

	logic [BW-1:0]     x_q;
	logic [BW-1:0]     y_q;
	logic [BW-1:0]     s_q;
	logic              sgn_q;
	logic signed [FW-1:0] f_q;
	logic signed [FW-1:0] t_q [3];
	logic [MAG_W-1:0]  m_q [3];
	logic [MAG_W-1:0]  lo_q;
	logic [MAG_W-1:0]  hi_q;
	logic [1:0]        idx_q;
	logic              def_q;

	logic [MAG_W:0]    mid_sum;
	logic [MAG_W-1:0]  mid;
	logic [MAG_W:0]    k;
	logic              f_def;

	function automatic logic [BW-1:0] mag_d(input logic signed [DW-1:0] x);
		logic [DW-1:0] m;
		m = x[DW-1] ? (~x + 1'b1) : x;
		return BW'(m);
	endfunction

	function automatic logic [BW-1:0] mag_f(input logic signed [FW-1:0] x);
		logic [FW-1:0] m;
		m = x[FW-1] ? (~x + 1'b1) : x;
		return BW'(m);
	endfunction

	function automatic logic signed [FW-1:0] sval(input logic [BW-1:0] m, input logic neg);
		logic signed [FW-1:0] v;
		v = signed'(m[FW-1:0]);
		return neg ? -v : v;
	endfunction

	ttg_mul #(.W(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
	assign mid     = mid_sum[MAG_W:1];
	assign k       = {mid, 1'b0} - 1'b1;
	assign f_def   = (f_q == '0) || (mag_f(f_q) < BW'({det_thr, 16'h0000}));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (start) state_d = C_F1;
			C_F1:   state_d = C_F1W;
			C_F1W:  if (mul_done) state_d = C_F2;
			C_F2:   state_d = C_F2W;
			C_F2W:  if (mul_done) state_d = C_FCHK;
			C_FCHK: state_d = f_def ? C_DONE : C_T1;
			C_T1:   state_d = C_T1W;
			C_T1W:  if (mul_done) state_d = C_T2;
			C_T2:   state_d = C_T2W;
			C_T2W:  if (mul_done) state_d = C_SQ;
			C_SQ:   state_d = C_SQW;
			C_SQW:  if (mul_done) state_d = (idx_q == 2'd2) ? C_SCHK : C_T1;
			C_SCHK: state_d = (s_q == '0) ? C_DONE : C_L2;
			C_L2:   state_d = C_L2W;
			C_L2W:  if (mul_done) state_d = C_FF;
			C_FF:   state_d = C_FFW;
			C_FFW:  if (mul_done) state_d = C_LR;
			C_LR:   state_d = C_LRW;
			C_LRW:  if (mul_done) state_d = ((s_q << 32) < mul_p) ? C_DONE : C_RT;
			C_RT:   state_d = C_RTW;
			C_RTW:  if (mul_done) state_d = C_BS;
			C_BS: begin
				if (lo_q < hi_q) begin
					state_d = C_K;
				end else begin
					state_d = (idx_q == 2'd2) ? C_DONE : C_RT;
				end
			end
			C_K:    state_d = C_KW;
			C_KW:   if (mul_done) state_d = C_KS;
			C_KS:   state_d = C_KSW;
			C_KSW:  if (mul_done) state_d = C_BS;
			C_DONE: state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			C_F1: begin
				mul_start = 1'b1;
				mul_a     = mag_d(du1);
				mul_b     = mag_d(dv2);
			end
			C_F2: begin
				mul_start = 1'b1;
				mul_a     = mag_d(du2);
				mul_b     = mag_d(dv1);
			end
			C_T1: begin
				mul_start = 1'b1;
				mul_a     = mag_d(dv2);
				mul_b     = mag_d(e1[idx_q]);
			end
			C_T2: begin
				mul_start = 1'b1;
				mul_a     = mag_d(dv1);
				mul_b     = mag_d(e2[idx_q]);
			end
			C_SQ, C_RT: begin
				mul_start = 1'b1;
				mul_a     = mag_f(t_q[idx_q]);
				mul_b     = mag_f(t_q[idx_q]);
			end
			C_L2: begin
				mul_start = 1'b1;
				mul_a     = BW'(len_thr);
				mul_b     = BW'(len_thr);
			end
			C_FF: begin
				mul_start = 1'b1;
				mul_a     = mag_f(f_q);
				mul_b     = mag_f(f_q);
			end
			C_LR: begin
				mul_start = 1'b1;
				mul_a     = x_q;
				mul_b     = y_q;
			end
			C_K: begin
				mul_start = 1'b1;
				mul_a     = BW'(k);
				mul_b     = BW'(k);
			end
			C_KS: begin
				mul_start = 1'b1;
				mul_a     = s_q;
				mul_b     = y_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		stat.done     = (state_q == C_DONE);
		stat.used_def = def_q;
		for (int i = 0; i < 3; i++) begin
			if (def_q) begin
				tan[i] = (i == 0) ? ONE_Q14 : '0;
			end else if (t_q[i][FW-1] != f_q[FW-1]) begin
				tan[i] = -signed'({1'b0, m_q[i]});
			end else begin
				tan[i] = signed'({1'b0, m_q[i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) def_q <= 1'b0;
			end
			C_F1W: begin
				if (mul_done) begin
					x_q   <= mul_p;
					sgn_q <= du1[DW-1] ^ dv2[DW-1];
				end
			end
			C_F2W: begin
				if (mul_done) f_q <= sval(x_q, sgn_q) - sval(mul_p, du2[DW-1] ^ dv1[DW-1]);
			end
			C_FCHK: begin
				if (f_def) def_q <= 1'b1;
				idx_q <= 2'd0;
				s_q   <= '0;
			end
			C_T1W: begin
				if (mul_done) begin
					x_q   <= mul_p;
					sgn_q <= dv2[DW-1] ^ e1[idx_q][DW-1];
				end
			end
			C_T2W: begin
				if (mul_done) begin
					t_q[idx_q] <= sval(x_q, sgn_q) - sval(mul_p, dv1[DW-1] ^ e2[idx_q][DW-1]);
				end
			end
			C_SQW: begin
				if (mul_done) begin
					s_q <= s_q + mul_p;
					if (idx_q != 2'd2) idx_q <= idx_q + 2'd1;
				end
			end
			C_SCHK: begin
				if (s_q == '0) def_q <= 1'b1;
			end
			C_L2W: begin
				if (mul_done) y_q <= mul_p;
			end
			C_FFW: begin
				if (mul_done) x_q <= mul_p;
			end
			C_LRW: begin
				if (mul_done) begin
					if ((s_q << 32) < mul_p) def_q <= 1'b1;
					idx_q <= 2'd0;
					lo_q  <= '0;
					hi_q  <= MAG_ONE;
				end
			end
			C_RTW: begin
				if (mul_done) x_q <= mul_p << 30;
			end
			C_BS: begin
				if (!(lo_q < hi_q)) begin
					m_q[idx_q] <= lo_q;
					if (idx_q != 2'd2) begin
						idx_q <= idx_q + 2'd1;
						lo_q  <= '0;
						hi_q  <= MAG_ONE;
					end
				end
			end
			C_KW: begin
				if (mul_done) y_q <= mul_p;
			end
			C_KSW: begin
				if (mul_done) begin
					if (!(x_q < mul_p)) begin
						lo_q <= mid;
					end else begin
						hi_q <= mid - 1'b1;
					end
				end
			end
			default: begin
				sgn_q <= sgn_q;
			end
		endcase
	end

endmodule

// ===== hdl/triangle_tangent_generator_unit.sv =====
// Channel | Dir | Bus                             | Contents
// s_      | in  | tvalid/tready/tdata/tlast       | one vertex: position, texcoord, list_last
// m_      | out | tvalid/tready/tdata/tlast/tuser | one tangent per vertex, run_last on tlast
// cfg_    | in  | we/addr/wdata                   | det_threshold, length_threshold
//
// The first two vertices of a triangle are each taken and stored while the unit is idle.
// The third vertex starts a sequence of products on one shift-add multiplier; each product
// steps through the bits of its second operand.
// A triangle that fails the determinant check ends after 2 products, one that fails the
// length check after 14 (11 if the tangent is zero); otherwise a 14- or 15-step search
// per tangent component adds up to 93 more products.
// Three output beats follow.
// No vertex is taken while a triangle is computed or output beats are pending.
// Reset clears control state and both thresholds.
module triangle_tangent_generator_unit #(
	parameter int COORD_WIDTH = 32,
	localparam int IN_W = ((5 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
	input  logic [IN_W-1:0]              s_tdata,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tan_x, tan_y, tan_z
	output logic [ttg_pkg::OUT_W-1:0]    m_tdata,
	output logic                         m_tlast,
	// used_default, list_done
	output logic [1:0]                   m_tuser,
	input  logic                         cfg_we,
	input  logic                         cfg_addr,
	input  logic [ttg_pkg::THR_W-1:0]    cfg_wdata
);
	import ttg_pkg::*;

	localparam int CW = COORD_WIDTH;

	top_state_t state_q, state_d;

	logic [1:0]           phase_q;
	logic [1:0]           cnt_q;
	logic [THR_W-1:0]     det_q;
	logic [THR_W-1:0]     len_q;

	logic signed [CW-1:0] in_p [3];
	logic signed [CW-1:0] in_u;
	logic signed [CW-1:0] in_v;
	logic signed [CW-1:0] p0_q [3];
	logic signed [CW-1:0] p1_q [3];
	logic signed [CW-1:0] u0_q, v0_q, u1_q, v1_q;

	logic signed [CW:0]   e1_q [3];
	logic signed [CW:0]   e2_q [3];
	logic signed [CW:0]   du1_q, dv1_q, du2_q, dv2_q;

	logic signed [TAN_W-1:0] tan_q [3];
	logic                 def_q;
	logic                 lst_q;

	logic                 accept;
	logic                 beat;
	logic                 core_start;
	core_stat_t           core_stat;
	logic signed [TAN_W-1:0] core_tan [3];

	function automatic logic signed [CW:0] diff(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

	assign in_p[0] = s_tdata[CW-1:0];
	assign in_p[1] = s_tdata[2*CW-1:CW];
	assign in_p[2] = s_tdata[3*CW-1:2*CW];
	assign in_u    = s_tdata[4*CW-1:3*CW];
	assign in_v    = s_tdata[5*CW-1:4*CW];

	assign accept = s_tvalid && s_tready;
	assign beat   = m_tvalid && m_tready;

	assign m_tdata = {tan_q[2], tan_q[1], tan_q[0]};
	assign m_tlast = (cnt_q == 2'd1);
	assign m_tuser = {lst_q && (cnt_q == 2'd1), def_q};

	ttg_core #(.CW(CW)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (core_start),
		.e1      (e1_q),
		.e2      (e2_q),
		.du1     (du1_q),
		.dv1     (dv1_q),
		.du2     (du2_q),
		.dv2     (dv2_q),
		.det_thr (det_q),
		.len_thr (len_q),
		.stat    (core_stat),
		.tan     (core_tan)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (phase_q != PH_V0 && phase_q != PH_V1) begin
						state_d = ST_START;
					end else if (s_tlast) begin
						state_d = ST_OUT;
					end
				end
			end
			ST_START: state_d = ST_BUSY;
			ST_BUSY:  if (core_stat.done) state_d = ST_OUT;
			ST_OUT:   if (m_tready && cnt_q == 2'd1) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		m_tvalid   = (state_q == ST_OUT);
		core_start = (state_q == ST_START);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_V0;
			cnt_q   <= 2'd0;
			det_q   <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_addr))
					REG_DET_THR: det_q <= cfg_wdata;
					REG_LEN_THR: len_q <= cfg_wdata;
				endcase
			end
			if (accept) begin
				unique case (phase_q)
					PH_V0: begin
						phase_q <= s_tlast ? PH_V0 : PH_V1;
						if (s_tlast) cnt_q <= 2'd1;
					end
					PH_V1: begin
						phase_q <= s_tlast ? PH_V0 : PH_V2;
						if (s_tlast) cnt_q <= 2'd2;
					end
					default: phase_q <= PH_V0;
				endcase
			end else if (core_stat.done) begin
				cnt_q <= 2'd3;
			end else if (beat) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (phase_q)
				PH_V0: begin
					p0_q <= in_p;
					u0_q <= in_u;
					v0_q <= in_v;
					tan_q[0] <= ONE_Q14;
					tan_q[1] <= '0;
					tan_q[2] <= '0;
					def_q    <= 1'b1;
					lst_q    <= 1'b1;
				end
				PH_V1: begin
					p1_q <= in_p;
					u1_q <= in_u;
					v1_q <= in_v;
					tan_q[0] <= ONE_Q14;
					tan_q[1] <= '0;
					tan_q[2] <= '0;
					def_q    <= 1'b1;
					lst_q    <= 1'b1;
				end
				default: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= diff(p1_q[i], p0_q[i]);
						e2_q[i] <= diff(in_p[i], p0_q[i]);
					end
					du1_q <= diff(u1_q, u0_q);
					dv1_q <= diff(v1_q, v0_q);
					du2_q <= diff(in_u, u0_q);
					dv2_q <= diff(in_v, v0_q);
					lst_q <= s_tlast;
				end
			endcase
		end else if (core_stat.done) begin
			tan_q <= core_tan;
			def_q <= core_stat.used_def;
		end
	end

endmodule

// ===== hdl/ttg_prop_chk.sv =====
module ttg_prop_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic                      m_tlast,
	input logic [1:0]                m_tuser,
	input logic [ttg_pkg::OUT_W-1:0] m_tdata
);
	import ttg_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while output beats are pending");

	a_default: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[TAN_W-1:0] == ONE_Q14
			&& m_tdata[OUT_W-1:TAN_W] == '0)
		else $error("default flag without the default tangent");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("list end not on the last beat of a run");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("output continued after the last beat of a run");

endmodule

bind triangle_tangent_generator_unit ttg_prop_chk u_prop_chk (.*);

// ===== bench/tangent_checker.sv =====
module tangent_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [159:0] s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic         m_tlast,
	input  logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [15:0]  cfg_wdata,
	output int           fails,
	output int           pending,
	output int           results_seen,
	output int           defaults_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import ttg_pkg::*;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [15:0] tz;
		logic               dflt;
		logic               rlast;
		logic               done;
	} tangent_t;

	tangent_t tangent_q[$];
	logic signed [31:0] held_pos[6];
	logic signed [31:0] held_tex[4];
	logic [1:0] phase;
	logic [15:0] det_thr;
	logic [15:0] len_thr;

	function automatic void queue_beat(input tangent_t r);
		tangent_q.insert(tangent_q.size(), r);
	endfunction

	function automatic logic signed [15:0] unit_component(input wide_t t, input wide_t s,
			input logic f_neg);
		wide_t lhs;
		wide_t k;
		int lo;
		int hi;
		int mid;
		lhs = t * t * (wide_t'(1) <<< 30);
		lo = 0;
		hi = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			k = wide_t'(2 * mid - 1);
			if (!(lhs < k * k * s)) lo = mid;
			else hi = mid - 1;
		end
		return ((t < 0) != f_neg) ? -16'(lo) : 16'(lo);
	endfunction

	function automatic tangent_t solve_triangle(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz,
			input logic signed [31:0] u, input logic signed [31:0] v);
		wide_t e1[3];
		wide_t e2[3];
		wide_t t[3];
		wide_t du1, dv1, du2, dv2, f, fa, s;
		logic signed [31:0] p2[3];
		tangent_t r;
		p2[0] = px;
		p2[1] = py;
		p2[2] = pz;
		for (int i = 0; i < 3; i++) begin
			e1[i] = wide_t'(held_pos[3+i]) - wide_t'(held_pos[i]);
			e2[i] = wide_t'(p2[i]) - wide_t'(held_pos[i]);
		end
		du1 = wide_t'(held_tex[2]) - wide_t'(held_tex[0]);
		dv1 = wide_t'(held_tex[3]) - wide_t'(held_tex[1]);
		du2 = wide_t'(u) - wide_t'(held_tex[0]);
		dv2 = wide_t'(v) - wide_t'(held_tex[1]);
		f = du1 * dv2 - du2 * dv1;
		fa = (f < 0) ? -f : f;
		r.dflt = (f == 0) || (fa < wide_t'({det_thr, 16'h0000}));
		s = 0;
		for (int i = 0; i < 3; i++) begin
			t[i] = dv2 * e1[i] - dv1 * e2[i];
			s = s + t[i] * t[i];
		end
		if (!r.dflt)
			r.dflt = (s == 0) ||
				((s <<< 32) < wide_t'(len_thr) * wide_t'(len_thr) * f * f);
		if (r.dflt) begin
			r.tx = ONE_Q14;
			r.ty = 0;
			r.tz = 0;
		end else begin
			r.tx = unit_component(t[0], s, f < 0);
			r.ty = unit_component(t[1], s, f < 0);
			r.tz = unit_component(t[2], s, f < 0);
		end
		r.rlast = 1'b0;
		r.done = 1'b0;
		return r;
	endfunction

	function automatic tangent_t default_tangent(input logic rl, input logic dn);
		tangent_t r;
		r.tx = ONE_Q14;
		r.ty = 0;
		r.tz = 0;
		r.dflt = 1'b1;
		r.rlast = rl;
		r.done = dn;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tangent_t exp_t;
		tangent_t got;
		logic signed [31:0] vx, vy, vz, vu, vv;
		if (!arst_n) begin
			tangent_q.delete();
			phase <= PH_V0;
			det_thr <= '0;
			len_thr <= '0;
			fails <= 0;
			pending <= 0;
			results_seen <= 0;
			defaults_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.tx = m_tdata[15:0];
				got.ty = m_tdata[31:16];
				got.tz = m_tdata[47:32];
				got.dflt = m_tuser[0];
				got.rlast = m_tlast;
				got.done = m_tuser[1];
				results_seen <= results_seen + 1;
				if (got.dflt) defaults_seen <= defaults_seen + 1;
				if (tangent_q.size() == 0) begin
					if (fails < 10) begin
						$write("%0t: tangent beat with nothing expected:", $realtime);
						$display(" %0d %0d %0d d%0b l%0b e%0b",
							got.tx, got.ty, got.tz, got.dflt, got.rlast, got.done);
					end
					fails <= fails + 1;
				end else begin
					exp_t = tangent_q.pop_front();
					if (got != exp_t) begin
						if (fails < 10) begin
							$write("%0t: tangent mismatch: expected %0d %0d %0d d%0b l%0b e%0b,",
								$realtime, exp_t.tx, exp_t.ty, exp_t.tz, exp_t.dflt,
								exp_t.rlast, exp_t.done);
							$display(" got %0d %0d %0d d%0b l%0b e%0b",
								got.tx, got.ty, got.tz, got.dflt, got.rlast, got.done);
						end
						fails <= fails + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				vx = s_tdata[31:0];
				vy = s_tdata[63:32];
				vz = s_tdata[95:64];
				vu = s_tdata[127:96];
				vv = s_tdata[159:128];
				if (phase == PH_V0) begin
					held_pos[0] = vx;
					held_pos[1] = vy;
					held_pos[2] = vz;
					held_tex[0] = vu;
					held_tex[1] = vv;
					if (s_tlast) queue_beat(default_tangent(1'b1, 1'b1));
					else phase <= PH_V1;
				end else if (phase == PH_V1) begin
					held_pos[3] = vx;
					held_pos[4] = vy;
					held_pos[5] = vz;
					held_tex[2] = vu;
					held_tex[3] = vv;
					if (s_tlast) begin
						queue_beat(default_tangent(1'b0, 1'b0));
						queue_beat(default_tangent(1'b1, 1'b1));
						phase <= PH_V0;
					end else begin
						phase <= PH_V2;
					end
				end else begin
					exp_t = solve_triangle(vx, vy, vz, vu, vv);
					queue_beat(exp_t);
					queue_beat(exp_t);
					exp_t.rlast = 1'b1;
					exp_t.done = s_tlast;
					queue_beat(exp_t);
					phase <= PH_V0;
				end
			end
			if (cfg_we) begin
				if (cfg_addr == REG_DET_THR) det_thr <= cfg_wdata;
				else len_thr <= cfg_wdata;
			end
			pending <= tangent_q.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ttg_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic         m_tlast;
	logic [1:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic         cfg_addr = REG_DET_THR;
	logic [15:0]  cfg_wdata = '0;

	int fails;
	int pending;
	int results_seen;
	int defaults_seen;
	int vertices_sent;
	int lists_sent;
	int settings_used;
	int burst_left;
	bit gaps_on;
	int stall_cnt;
	int ready_duty;
	int scale;

	always #6 clk = ~clk;

	triangle_tangent_generator_unit #(.COORD_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	tangent_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.fails(fails), .pending(pending), .results_seen(results_seen),
		.defaults_seen(defaults_seen)
	);

	// The receiver switches between duty levels, including stretches with no stall.
	initial begin
		stall_cnt = 0;
		ready_duty = 100;
	end

	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			case ($urandom_range(0, 3))
				0: ready_duty = 100;
				1: ready_duty = 75;
				2: ready_duty = 30;
				default: ready_duty = 5;
			endcase
			stall_cnt = $urandom_range(20, 300);
		end else begin
			stall_cnt = stall_cnt - 1;
		end
		m_tready <= ($urandom_range(0, 99) < ready_duty);
	end

	task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] u, input logic [31:0] v,
			input logic last);
		logic rdy;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {v, u, z, y, x};
		s_tlast <= last;
		forever begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
			if (rdy) break;
		end
		vertices_sent++;
		if (last) lists_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_tangents();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_thresholds(input logic [15:0] det, input logic [15:0] len);
		cfg_we <= 1'b1;
		cfg_addr <= REG_DET_THR;
		cfg_wdata <= det;
		@(posedge clk);
		cfg_addr <= REG_LEN_THR;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [31:0] coord();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return 32'($signed($urandom_range(0, (1 << scale) - 1)) - (1 << (scale - 1)));
	endfunction

	task automatic send_list(input int len);
		logic [31:0] px, py, pz, pu, pv;
		logic [31:0] x0, y0, z0;
		px = coord();
		py = coord();
		pz = coord();
		pu = coord();
		pv = coord();
		for (int i = 0; i < len; i++) begin
			if (i % 3 == 0) begin
				x0 = px;
				y0 = py;
				z0 = pz;
			end
			case ($urandom_range(0, 19))
				0: begin
				end
				1: begin
					px = x0;
					py = y0;
					pz = z0;
				end
				2: begin
					px = coord();
					py = coord();
					pz = coord();
				end
				default: begin
					px = coord();
					py = coord();
					pz = coord();
					pu = coord();
					pv = coord();
				end
			endcase
			send_vertex(px, py, pz, pu, pv, i == len - 1);
		end
	endtask

	initial begin
		int budget;
		int len;
		vertices_sent = 0;
		lists_sent = 0;
		settings_used = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_thresholds(16'h0000, 16'h0000);

		send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1);
		send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
		send_vertex(32'hffffffff, 32'h00000000, 32'h00010000, 32'h00000000, 32'hffffffff, 1'b1);
		send_vertex(32'h00010000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0);
		send_vertex(32'h00020000, 32'h00010000, 32'h00000000, 32'h00010000, 32'h00010000, 1'b0);
		send_vertex(32'h00030000, 32'h00000000, 32'h00050000, 32'h00020000, 32'h00020000, 1'b0);
		send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 32'h00000000, 32'h00000000, 1'b0);
		send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 32'h00000000, 1'b0);
		send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 32'h00000000, 32'h00010000, 1'b0);
		send_vertex(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0);
		send_vertex(32'h00010000, 32'h00000000, 32'h00000000, 32'h00010000, 32'h00000000, 1'b0);
		send_vertex(32'h00000000, 32'h00010000, 32'h00000000, 32'h00000000, 32'h00010000, 1'b1);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
		send_vertex(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
		send_vertex(32'h00000001, 32'hfffffffe, 32'h00000003, 32'h00000001, 32'h00000000, 1'b0);
		send_vertex(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000002, 1'b0);
		send_vertex(32'h00000002, 32'h00000001, 32'h00000000, 32'h00000003, 32'h00000001, 1'b1);
		drain_tangents();

		budget = 480;
		for (int phase_n = 0; phase_n < 6; phase_n++) begin
			case (phase_n)
				0: write_thresholds(16'hffff, 16'h0000);
				1: write_thresholds(16'h0000, 16'hffff);
				2: write_thresholds(16'hffff, 16'hffff);
				default: write_thresholds(16'($urandom_range(0, 65535) >> $urandom_range(0, 15)),
					16'($urandom_range(0, 65535) >> $urandom_range(0, 15)));
			endcase
			gaps_on = (phase_n != 2);
			for (int k = 0; k < 80 && budget > 0; k += len) begin
				scale = $urandom_range(2, 31);
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 3 * $urandom_range(1, 6);
				if ($urandom_range(0, 7) == 0) len = len + $urandom_range(1, 2);
				if (len > budget) len = budget;
				send_list(len);
				budget -= len;
				if ($urandom_range(0, 9) == 0) drain_tangents();
			end
			drain_tangents();
		end

		repeat (50) @(posedge clk);
		$display("Sent %0d vertices in %0d lists over %0d threshold settings;", vertices_sent,
			lists_sent, settings_used);
		$display("checked %0d tangent beats, %0d of them defaults.", results_seen, defaults_seen);
		if (fails == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches", fails);
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#240000000;
		$display("Timed out with %0d tangents outstanding", pending);
		$display("testbench NOT OK");
		$finish;
	end

endmodule
